@@ hw/rtl/kmds_pkg.sv @@
// ----------------------------------------------------------------------------
// kmds_pkg
// Shared types and constants for the key matrix debounce scanner.
// ----------------------------------------------------------------------------
package kmds_pkg;

  // Fixed storage and field sizes.
  localparam int KEY_STORE  = 64;
  localparam int LEVEL_BITS = 8;
  localparam int ADDR_W     = 6;
  localparam int CNT_W      = 8;
  localparam int DEB_W      = 7;
  localparam int ROW_W      = 3;
  localparam int COL_SEL_W  = 3;
  localparam int COL_W      = 4;
  localparam int IDX_W      = 8;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [DEB_W-1:0] DEB_RESET = 7'd5;

  // Register index as seen in paddr[2].
  localparam logic REG_DEBOUNCE = 1'b0;

  // One row sample.
  typedef struct packed {
    logic [ROW_W-1:0]      row_index;
    logic [LEVEL_BITS-1:0] column_levels;
  } kmds_in_t;

  // One key event.
  typedef struct packed {
    logic [ADDR_W-1:0] key_index;
    logic              is_release;
    logic              last;
  } kmds_out_t;

  // Result of the shared counter unit for one key.
  typedef struct packed {
    logic [CNT_W-1:0] cnt_nxt;
    logic             wr;
    logic             evt;
    logic             is_release;
  } kmds_unit_t;

endpackage

@@ hw/rtl/kmds_key_unit.sv @@
// ----------------------------------------------------------------------------
// kmds_key_unit
// Debounce counter update for one key: compares, reloads and decrements its counter.
// ----------------------------------------------------------------------------
module kmds_key_unit
  import kmds_pkg::*;
(
  input  logic [CNT_W-1:0] cnt,
  input  logic             high,
  input  logic [DEB_W-1:0] deb,
  output kmds_unit_t       res
);

  logic [CNT_W-1:0] deb_x;
  logic [CNT_W-1:0] deb_p1;
  logic [CNT_W-1:0] deb2;
  logic [CNT_W-1:0] cnt_dec;

  assign deb_x   = {1'b0, deb};
  assign deb_p1  = deb_x + CNT_W'(1);
  assign deb2    = {deb, 1'b0};
  assign cnt_dec = cnt - CNT_W'(1);

  // Press start, lockout countdown, hold, release and release countdown.
  always_comb begin
    res = '0;
    res.cnt_nxt = cnt;
    if ((cnt == '0) && !high) begin
      res.cnt_nxt = deb2;
      res.wr      = 1'b1;
      res.evt     = 1'b1;
    end else if (cnt > deb_p1) begin
      res.cnt_nxt = cnt_dec;
      res.wr      = 1'b1;
    end else if ((cnt == deb_p1) && high) begin
      res.cnt_nxt    = cnt_dec;
      res.wr         = 1'b1;
      res.evt        = 1'b1;
      res.is_release = 1'b1;
    end else if ((cnt != '0) && (cnt <= deb_x)) begin
      res.cnt_nxt = cnt_dec;
      res.wr      = 1'b1;
    end
  end

endmodule

@@ hw/rtl/key_matrix_debounce_scanner.sv @@
// ----------------------------------------------------------------------------
// key_matrix_debounce_scanner
// Per-key debounce for a scanned key matrix, emitting press/release events.
// ----------------------------------------------------------------------------
// Each input request carries the column levels sampled while one row was
// driven. The block walks the columns of that row one per cycle through a
// single counter unit, reading and writing a 64-entry counter memory, then
// sends the press and release events of the row in column order, the final
// one marked with last. The walk covers min(COLS,8) columns; the events then
// go out one per cycle while the receiver keeps out_ready high. A row at or
// above ROWS is accepted without a scan and yields no events. in_ready is
// high only while the block is idle.
// If the receiver stalls, the output register holds its event and the block
// waits in its send phase; it returns to idle once the last event of the row
// is registered, even if that event has not yet been taken.
// Reset clears all key counters at once (per-entry valid bits) and sets
// debounce_ticks to 5; no clearing pass is needed.
// debounce_ticks sits at address 0 of the configuration port.
// ----------------------------------------------------------------------------
module key_matrix_debounce_scanner
  import kmds_pkg::*;
#(
  parameter int ROWS = 8,
  parameter int COLS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  kmds_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output kmds_out_t             out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int NCOLS = (COLS < LEVEL_BITS) ? COLS : LEVEL_BITS;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t                state_r, state_nxt;
  logic [DEB_W-1:0]      deb_r;
  logic [LEVEL_BITS-1:0] levels_r, levels_nxt;
  logic [IDX_W-1:0]      base_r, base_nxt;
  logic [COL_W-1:0]      rd_col_r, rd_col_nxt;
  logic                  upd_vld_r, upd_vld_nxt;
  logic [COL_SEL_W-1:0]  upd_col_r, upd_col_nxt;
  logic [ADDR_W-1:0]     upd_addr_r, upd_addr_nxt;
  logic [LEVEL_BITS-1:0] ev_r, ev_nxt;
  logic [LEVEL_BITS-1:0] rel_r, rel_nxt;
  logic                  out_valid_r, out_valid_nxt;
  kmds_out_t             out_data_r, out_data_nxt;

  logic [CNT_W-1:0]      mem [KEY_STORE];
  logic [KEY_STORE-1:0]  vld_r;
  logic [CNT_W-1:0]      mem_q_r;
  logic                  vld_q_r;

  logic                  in_acc;
  logic                  cfg_wr;
  logic [IDX_W-1:0]      rd_idx;
  logic                  rd_en;
  logic [CNT_W-1:0]      cur_cnt;
  kmds_unit_t            unit_res;
  logic                  mem_we;
  logic [LEVEL_BITS-1:0] pick_oh;
  logic [COL_SEL_W-1:0]  pick_col;
  logic                  pick_found;
  logic [IDX_W-1:0]      emit_idx;

  assign in_ready   = (state_r == S_IDLE);
  assign in_acc     = in_valid && in_ready;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign cfg_pready = 1'b1;

  // Configuration register write and readback.
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == REG_DEBOUNCE);

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_DEBOUNCE) begin
      cfg_prdata = CFG_DATA_W'(deb_r);
    end
  end

  // Read side: address of the column being fetched this cycle.
  assign rd_idx = base_r + IDX_W'(rd_col_r);
  assign rd_en  = (state_r == S_SCAN) && (rd_col_r < COL_W'(NCOLS))
                  && (rd_idx < IDX_W'(KEY_STORE));

  // Counter value of the key fetched last cycle; never-written keys read zero.
  assign cur_cnt = vld_q_r ? mem_q_r : '0;

  kmds_key_unit u_unit (
    .cnt  (cur_cnt),
    .high (levels_r[upd_col_r]),
    .deb  (deb_r),
    .res  (unit_res)
  );

  assign mem_we = upd_vld_r && unit_res.wr;

  // Lowest pending event of the row.
  always_comb begin
    pick_oh    = '0;
    pick_col   = '0;
    pick_found = 1'b0;
    for (int i = 0; i < LEVEL_BITS; i++) begin
      if (ev_r[i] && !pick_found) begin
        pick_found = 1'b1;
        pick_oh[i] = 1'b1;
        pick_col   = COL_SEL_W'(i);
      end
    end
  end

  assign emit_idx = base_r + IDX_W'(pick_col);

  // Sequencer: accept, column walk, event send.
  always_comb begin
    state_nxt     = state_r;
    levels_nxt    = levels_r;
    base_nxt      = base_r;
    rd_col_nxt    = rd_col_r;
    upd_vld_nxt   = 1'b0;
    upd_col_nxt   = upd_col_r;
    upd_addr_nxt  = upd_addr_r;
    ev_nxt        = ev_r;
    rel_nxt       = rel_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (32'(in_data.row_index) < ROWS)) begin
          state_nxt  = S_SCAN;
          levels_nxt = in_data.column_levels;
          base_nxt   = IDX_W'(in_data.row_index) * IDX_W'(COLS);
          rd_col_nxt = '0;
          ev_nxt     = '0;
          rel_nxt    = '0;
        end
      end
      S_SCAN: begin
        if (rd_col_r < COL_W'(NCOLS)) begin
          rd_col_nxt   = rd_col_r + COL_W'(1);
          upd_vld_nxt  = rd_en;
          upd_col_nxt  = rd_col_r[COL_SEL_W-1:0];
          upd_addr_nxt = rd_idx[ADDR_W-1:0];
        end else if (!upd_vld_r) begin
          state_nxt = S_EMIT;
        end
        if (upd_vld_r) begin
          ev_nxt[upd_col_r]  = unit_res.evt;
          rel_nxt[upd_col_r] = unit_res.is_release;
        end
      end
      S_EMIT: begin
        if (!pick_found) begin
          state_nxt = S_IDLE;
        end else if (!out_valid_r || out_ready) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.key_index  = emit_idx[ADDR_W-1:0];
          out_data_nxt.is_release = |(rel_r & pick_oh);
          out_data_nxt.last       = ((ev_r & ~pick_oh) == '0);
          ev_nxt                  = ev_r & ~pick_oh;
          if ((ev_r & ~pick_oh) == '0) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      deb_r       <= DEB_RESET;
      rd_col_r    <= '0;
      upd_vld_r   <= 1'b0;
      ev_r        <= '0;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      rd_col_r    <= rd_col_nxt;
      upd_vld_r   <= upd_vld_nxt;
      ev_r        <= ev_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        deb_r <= cfg_pwdata[DEB_W-1:0];
      end
      if (mem_we) begin
        vld_r[upd_addr_r] <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    levels_r   <= levels_nxt;
    base_r     <= base_nxt;
    upd_col_r  <= upd_col_nxt;
    upd_addr_r <= upd_addr_nxt;
    rel_r      <= rel_nxt;
    out_data_r <= out_data_nxt;
  end

  // Counter memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[upd_addr_r] <= unit_res.cnt_nxt;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_idx[ADDR_W-1:0]];
      vld_q_r <= vld_r[rd_idx[ADDR_W-1:0]];
    end
  end

endmodule
